/* hdl/lfa_pkg.sv */
// Package for the lowest-free identifier allocator: sizes, codes, state type and search helper.
`default_nettype none

package lfa_pkg;

	// Bitmap geometry. NUM_IDS must be a multiple of WORD_W and give 64 words (8 groups of 8).
	localparam int NUM_IDS     = 4096;
	localparam int ID_W        = 16;
	localparam int IDX_W       = $clog2(NUM_IDS);
	localparam int WORD_W      = 64;
	localparam int BIT_W       = $clog2(WORD_W);
	localparam int NUM_WORDS   = NUM_IDS / WORD_W;
	localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
	localparam int GROUP_W     = 8;
	localparam int NUM_GROUPS  = NUM_WORDS / GROUP_W;
	localparam int BYTES_W     = WORD_W / GROUP_W;

	localparam logic [ID_W:0]   NUM_IDS_EXT = (ID_W + 1)'(NUM_IDS);
	localparam logic [ID_W-1:0] BASE_RESET  = 16'd300;

	// Action codes.
	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_CLEAR   = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC_SUM,
		S_ALLOC_PICK,
		S_ALLOC_READ,
		S_ALLOC_BIT,
		S_REL_READ,
		S_REL_MOD,
		S_RESULT
	} state_t;

	// Result of a lowest-zero search over eight bits.
	typedef struct packed {
		logic       found;
		logic [2:0] idx;
	} lz8_t;

	function automatic lz8_t lowest_zero8(input logic [7:0] v);
		lz8_t r;
		r.found = 1'b0;
		r.idx   = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!v[i]) begin
				r.found = 1'b1;
				r.idx   = 3'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/lfa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module lfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/lowest_free_id_allocator.sv */
// Top level of the lowest-free identifier allocator: control sequencer, summary bits and bitmap RAM.
//
// Channel     | Direction | Contents
// ------------+-----------+---------------------------------------------------------------
// s_axis      | in        | tuser[1:0] action, tdata[15:0] release_id
// m_axis      | out       | tdata[15:0] granted_id, tuser[1:0] status
// cfg_wr      | in        | wr_data[15:0] base_id, written when wr_en is high
//
// An allocate steps through ALLOC_SUM, ALLOC_PICK, ALLOC_READ and ALLOC_BIT, a release through
// REL_READ and REL_MOD, and a clear or the unused action goes straight to RESULT; the block works
// on one item at a time. Allocate time is set by the two-level search (an 8x8 registered tree
// over the per-word full bits, then an 8x8 search inside the word read from the bitmap RAM).
// Reset clears every valid and full bit at once, so no clearing pass is needed.
// A finished result waits in the output register while the next item is taken in;
// if that register is still occupied when the next result is ready, the sequencer holds.
`default_nettype none

module lowest_free_id_allocator
	import lfa_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	// Input stream.
	input  wire               s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire  [15:0]       s_axis_tdata,  // [15:0] release_id
	input  wire  [1:0]        s_axis_tuser,  // [1:0] action
	// Result stream.
	output logic              m_axis_tvalid,
	input  wire               m_axis_tready,
	output logic [15:0]       m_axis_tdata,  // [15:0] granted_id
	output logic [1:0]        m_axis_tuser,  // [1:0] status
	// Base identifier register.
	input  wire               cfg_wr_en,
	input  wire  [ID_W-1:0]   cfg_wr_data
);

	state_t state_q, state_d;

	// Control state.
	logic [ID_W-1:0]      base_q;
	logic [NUM_WORDS-1:0] valid_q;   // word has been written since the last clear
	logic [NUM_WORDS-1:0] full_q;    // word has every bit in use
	logic                 m_valid_q;

	// Item and working registers.
	logic [ID_W-1:0]       rel_q;
	logic [WORD_IDX_W-1:0] widx_q;
	logic [BIT_W-1:0]      bit_q;
	logic [WORD_W-1:0]     word_q;
	lz8_t                  grp_lz_s1 [NUM_GROUPS];
	lz8_t                  byte_lz_s2 [BYTES_W];
	logic [ID_W-1:0]       res_id_q;
	logic [1:0]            res_st_q;
	logic [ID_W-1:0]       m_data_q;
	logic [1:0]            m_user_q;

	// RAM interface.
	logic                  ram_we, ram_re;
	logic [WORD_IDX_W-1:0] ram_waddr, ram_raddr;
	logic [WORD_W-1:0]     ram_wdata, ram_rdata;

	// Datapath helpers.
	logic [NUM_GROUPS-1:0] grp_busy;
	lz8_t                  grp_pick;
	logic [WORD_IDX_W-1:0] alloc_widx;
	logic [WORD_W-1:0]     rd_word;
	logic [BYTES_W-1:0]    byte_busy;
	lz8_t                  byte_pick;
	logic [BIT_W-1:0]      alloc_bit;
	logic [WORD_W-1:0]     alloc_word;
	logic [WORD_W-1:0]     rel_word;
	logic [ID_W-1:0]       rel_off;
	logic                  rel_in_range;
	logic                  out_free;
	logic                  in_xfer;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	// Pick the lowest group that still has a word with a free bit, then the word in it.
	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			grp_busy[g] = !grp_lz_s1[g].found;
		end
		grp_pick   = lowest_zero8(grp_busy);
		alloc_widx = {grp_pick.idx, grp_lz_s1[grp_pick.idx].idx};
	end

	// A word never written since the last clear reads as all free.
	assign rd_word = valid_q[widx_q] ? ram_rdata : '0;

	// Pick the lowest byte with a free bit, then the bit in it.
	always_comb begin
		for (int b = 0; b < BYTES_W; b++) begin
			byte_busy[b] = !byte_lz_s2[b].found;
		end
		byte_pick  = lowest_zero8(byte_busy);
		alloc_bit  = {byte_pick.idx, byte_lz_s2[byte_pick.idx].idx};
		alloc_word = word_q | ({{(WORD_W-1){1'b0}}, 1'b1} << alloc_bit);
		rel_word   = rd_word & ~({{(WORD_W-1){1'b0}}, 1'b1} << bit_q);
	end

	// Offset of the identifier to free, modulo 65536.
	assign rel_off      = rel_q - base_q;
	assign rel_in_range = {1'b0, rel_off} < NUM_IDS_EXT;

	// Next state and RAM control.
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = widx_q;
		ram_raddr = alloc_widx;
		ram_wdata = alloc_word;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					unique case (s_axis_tuser)
						ACT_ALLOC:   state_d = S_ALLOC_SUM;
						ACT_RELEASE: state_d = S_REL_READ;
						default:     state_d = S_RESULT;
					endcase
				end
			end
			S_ALLOC_SUM: begin
				state_d = S_ALLOC_PICK;
			end
			S_ALLOC_PICK: begin
				if (grp_pick.found) begin
					ram_re  = 1'b1;
					state_d = S_ALLOC_READ;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_ALLOC_READ: begin
				state_d = S_ALLOC_BIT;
			end
			S_ALLOC_BIT: begin
				ram_we  = 1'b1;
				state_d = S_RESULT;
			end
			S_REL_READ: begin
				ram_raddr = rel_off[IDX_W-1:BIT_W];
				if (rel_in_range) begin
					ram_re  = 1'b1;
					state_d = S_REL_MOD;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_REL_MOD: begin
				ram_we    = 1'b1;
				ram_wdata = rel_word;
				state_d   = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: base, summary bits and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= BASE_RESET;
			valid_q   <= '0;
			full_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
			if (state_q == S_IDLE && in_xfer && s_axis_tuser == ACT_CLEAR) begin
				valid_q <= '0;
				full_q  <= '0;
			end
			if (state_q == S_ALLOC_BIT) begin
				valid_q[widx_q] <= 1'b1;
				full_q[widx_q]  <= &alloc_word;
			end
			if (state_q == S_REL_MOD) begin
				valid_q[widx_q] <= 1'b1;
				full_q[widx_q]  <= 1'b0;
			end
			if (state_q == S_RESULT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Item, search and result registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rel_q    <= s_axis_tdata;
			res_id_q <= '0;
			res_st_q <= ST_DONE;
		end
		if (state_q == S_ALLOC_SUM) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				grp_lz_s1[g] <= lowest_zero8(full_q[g*GROUP_W +: GROUP_W]);
			end
		end
		if (state_q == S_ALLOC_PICK) begin
			widx_q <= alloc_widx;
			if (!grp_pick.found) begin
				res_st_q <= ST_FULL;
			end
		end
		if (state_q == S_ALLOC_READ) begin
			word_q <= rd_word;
			for (int b = 0; b < BYTES_W; b++) begin
				byte_lz_s2[b] <= lowest_zero8(rd_word[b*GROUP_W +: GROUP_W]);
			end
		end
		if (state_q == S_ALLOC_BIT) begin
			res_id_q <= base_q + ID_W'({widx_q, alloc_bit});
		end
		if (state_q == S_REL_READ) begin
			widx_q <= rel_off[IDX_W-1:BIT_W];
			bit_q  <= rel_off[BIT_W-1:0];
			if (!rel_in_range) begin
				res_st_q <= ST_RANGE;
			end
		end
		if (state_q == S_RESULT && out_free) begin
			m_data_q <= res_id_q;
			m_user_q <= res_st_q;
		end
	end

	lfa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// A new item is taken only while the sequencer is idle.
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

/* hdl/lfa_checker.sv */
// Port-level checker for the lowest-free identifier allocator, bound to the top level.
`default_nettype none

module lfa_checker
	import lfa_pkg::*;
(
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [15:0] m_axis_tdata,
	input wire [1:0]  m_axis_tuser
);

	// A result that is not taken holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// A result with a failed status carries identifier zero.
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_DONE |-> m_axis_tdata == 16'd0)
		else $error("nonzero identifier on a failed result");

	// One item at a time: after an input transfer the input side closes.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while one is in work");

	// Status never takes the unused code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("unused status code");

	// Nothing is offered during reset.
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("result offered during reset");

endmodule

bind lowest_free_id_allocator lfa_checker u_lfa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* test/id_pool_tb_pkg.sv */
// Scoreboard class for the lowest-free identifier allocator testbench: bitmap predictor and reply queue.
`timescale 1ns / 1ps

package id_pool_tb_pkg;
	import lfa_pkg::*;

	// The action code that the block has to ignore.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [1:0]      status;
	} reply_t;

	class id_pool_tracker;
		bit [NUM_IDS-1:0] in_use;
		bit [ID_W-1:0]    base;
		reply_t           expected_replies[$];
		int errors;
		int n_requests;
		int n_grants;
		int n_full;
		int n_range;
		int n_freed;
		int n_clears;
		int n_ignored;
		int n_checked;

		function new();
			in_use = '0;
			base   = BASE_RESET;
		endfunction

		function void set_base(input bit [ID_W-1:0] value);
			base = value;
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		// Applies one accepted request to the bitmap and queues the reply it must cause.
		function void take_request(input logic [1:0] action, input logic [ID_W-1:0] rel_id);
			reply_t          r;
			bit [ID_W-1:0]   offset;
			bit              hit;
			r.id      = '0;
			r.status  = ST_DONE;
			hit       = 1'b0;
			n_requests++;
			case (action)
				ACT_ALLOC: begin
					for (int i = 0; i < NUM_IDS; i++) begin
						if (!in_use[i]) begin
							in_use[i] = 1'b1;
							r.id      = base + ID_W'(i);
							hit       = 1'b1;
							break;
						end
					end
					if (hit) begin
						n_grants++;
					end else begin
						r.status = ST_FULL;
						n_full++;
					end
				end
				ACT_RELEASE: begin
					// The offset wraps modulo 65536, so identifiers just below the base are out of range.
					offset = rel_id - base;
					if (offset < NUM_IDS) begin
						in_use[offset[IDX_W-1:0]] = 1'b0;
						n_freed++;
					end else begin
						r.status = ST_RANGE;
						n_range++;
					end
				end
				ACT_CLEAR: begin
					in_use = '0;
					n_clears++;
				end
				default: begin
					n_ignored++;
				end
			endcase
			expected_replies.push_back(r);
		endfunction

		// Compares one reply transfer with the oldest queued reply, field by field.
		function void check_reply(input logic [ID_W-1:0] id, input logic [1:0] status);
			reply_t want;
			if (expected_replies.size() == 0) begin
				$display("%0t: reply with nothing pending, expected none, actual id %h status %0d",
					$time, id, status);
				errors++;
				return;
			end
			want = expected_replies.pop_front();
			n_checked++;
			if (id !== want.id) begin
				$display("%0t: granted_id mismatch, expected %h, actual %h", $time, want.id, id);
				errors++;
			end
			if (status !== want.status) begin
				$display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status,
					status);
				errors++;
			end
		endfunction
	endclass

endpackage

/* test/tb_lowest_free_id_allocator.sv */
// Testbench top for the lowest-free identifier allocator: stimulus, back-pressure and watchdog.
`timescale 1ns / 1ps

module tb_lowest_free_id_allocator;
	import lfa_pkg::*;
	import id_pool_tb_pkg::*;

	// A run is stopped when this many cycles in a row pass without any transfer.
	localparam int STALL_LIMIT = 4000;

	logic            clk;
	logic            arst_n;
	logic            s_axis_tvalid;
	logic            s_axis_tready;
	logic [15:0]     s_axis_tdata;   // [15:0] release_id
	logic [1:0]      s_axis_tuser;   // [1:0] action
	logic            m_axis_tvalid;
	logic            m_axis_tready;
	logic [15:0]     m_axis_tdata;   // [15:0] granted_id
	logic [1:0]      m_axis_tuser;   // [1:0] status
	logic            cfg_wr_en;
	logic [ID_W-1:0] cfg_wr_data;

	id_pool_tracker pool;
	// While set, the sender picks no random gaps and the receiver never stalls.
	bit  steady_flow;
	int  idle_cycles;
	int  base_writes;

	lowest_free_id_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Gap lengths for both sides: usually none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Presents one request from a falling edge and holds it until its transfer. The task
	// returns at the next falling edge with tvalid still high, so a following request with
	// no gap goes out back to back without tvalid ever dropping.
	task automatic send_request(input logic [1:0] action, input logic [15:0] rel_id);
		int gap;
		gap = steady_flow ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tuser  = action;
		s_axis_tdata  = rel_id;
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pool.take_request(action, rel_id);
		@(negedge clk);
	endtask

	// Stops sending and waits until every queued reply has come out of the block.
	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (pool.pending() != 0)
			@(negedge clk);
	endtask

	// The base register may only change while the block is idle, so drain first. The bitmap
	// keeps its contents across the write; only the numbering moves.
	task automatic write_base(input logic [ID_W-1:0] value);
		wait_drained();
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 16'($urandom_range(0, 65535));
		pool.set_base(value);
		base_writes++;
	endtask

	// One random request. Most are allocates and releases of identifiers near the base,
	// where the granted entries live; the rest are wild releases, edge-of-range releases,
	// clears and the ignored action code.
	task automatic random_request();
		int          r;
		logic [15:0] id;
		r  = $urandom_range(0, 99);
		id = 16'($urandom_range(0, 65535));
		if (r < 50) begin
			send_request(ACT_ALLOC, id);
		end else if (r < 78) begin
			send_request(ACT_RELEASE, pool.base + 16'($urandom_range(0, 47)));
		end else if (r < 88) begin
			send_request(ACT_RELEASE, id);
		end else if (r < 92) begin
			if ($urandom_range(0, 1))
				id = pool.base - 16'(1 + $urandom_range(0, 3));
			else
				id = pool.base + 16'(NUM_IDS + $urandom_range(0, 3));
			send_request(ACT_RELEASE, id);
		end else if (r < 95) begin
			send_request(ACT_CLEAR, id);
		end else begin
			send_request(ACT_UNUSED, id);
		end
		// Once in a while the sender holds off until the block has answered everything.
		if ($urandom_range(0, 99) == 0)
			wait_drained();
	endtask

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++)
			random_request();
	endtask

	// Receiver side: tready is changed only at falling edges, with random stalls unless the
	// phase runs with steady flow.
	initial begin
		int stall;
		stall         = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0 && !steady_flow) begin
				stall--;
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = 1'b1;
				stall = steady_flow ? 0 : pick_gap();
			end
		end
	end

	// Every reply transfer is checked at the rising edge where it happens.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			pool.check_reply(m_axis_tdata, m_axis_tuser);
	end

	// The watchdog counts cycles in which neither side makes a transfer.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [15:0] fill_base;
		pool          = new();
		steady_flow   = 1'b0;
		idle_cycles   = 0;
		base_writes   = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = ACT_ALLOC;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part on the reset base of 300. The release_id of an allocate is ignored,
		// so both of its extremes go along with the first grants.
		send_request(ACT_ALLOC, 16'h0000);
		send_request(ACT_ALLOC, 16'hFFFF);
		send_request(ACT_ALLOC, 16'h1234);
		send_request(ACT_ALLOC, 16'h0000);
		// A freed hole below used entries must be the next grant.
		send_request(ACT_RELEASE, 16'd301);
		send_request(ACT_ALLOC, 16'h0000);
		// Releasing an entry twice leaves it free and still reports done.
		send_request(ACT_RELEASE, 16'd302);
		send_request(ACT_RELEASE, 16'd302);
		// Just below the base and just past the last entry are out of range; the last
		// entry itself is in range even while free.
		send_request(ACT_RELEASE, 16'd299);
		send_request(ACT_RELEASE, 16'(300 + NUM_IDS));
		send_request(ACT_RELEASE, 16'(300 + NUM_IDS - 1));
		send_request(ACT_RELEASE, 16'h0000);
		send_request(ACT_RELEASE, 16'hFFFF);
		// The unused action code changes nothing.
		send_request(ACT_UNUSED, 16'hFFFF);
		send_request(ACT_UNUSED, 16'h0000);
		send_request(ACT_ALLOC, 16'h0000);
		send_request(ACT_CLEAR, 16'h0000);
		send_request(ACT_ALLOC, 16'h0000);
		send_request(ACT_RELEASE, 16'd300);
		send_request(ACT_CLEAR, 16'hFFFF);
		send_request(ACT_ALLOC, 16'hFFFF);

		// Lowest base, random traffic with gaps on both sides.
		write_base(16'd0);
		random_phase(200);

		// Highest base in the normal range, with the bitmap carried over and steady flow.
		write_base(16'd61440);
		steady_flow = 1'b1;
		random_phase(150);
		steady_flow = 1'b0;

		// A base close to the top, so grants and releases wrap past 65535.
		write_base(16'd65500);
		random_phase(150);

		// A long run of allocates that fills several words in a row, then a few holes
		// punched into the run and refilled.
		fill_base = 16'($urandom_range(0, 61440));
		write_base(fill_base);
		send_request(ACT_CLEAR, 16'($urandom_range(0, 65535)));
		for (int i = 0; i < 300; i++)
			send_request(ACT_ALLOC, 16'($urandom_range(0, 65535)));
		for (int i = 0; i < 3; i++)
			send_request(ACT_RELEASE, fill_base + 16'($urandom_range(0, 299)));
		for (int i = 0; i < 4; i++)
			send_request(ACT_ALLOC, 16'($urandom_range(0, 65535)));
		send_request(ACT_RELEASE, fill_base - 16'd1);
		send_request(ACT_CLEAR, 16'($urandom_range(0, 65535)));

		// Back on the reset value, with a full drain in the middle of the traffic.
		write_base(BASE_RESET);
		random_phase(100);
		wait_drained();
		random_phase(100);

		// A random base to finish.
		write_base(16'($urandom_range(0, 61440)));
		random_phase(100);

		wait_drained();
		repeat (20) @(negedge clk);

		$display("Ran %0d requests under %0d base writes, %0d replies checked.",
			pool.n_requests, base_writes, pool.n_checked);
		$display("Saw %0d grants, %0d full, %0d releases, %0d out of range,",
			pool.n_grants, pool.n_full, pool.n_freed, pool.n_range);
		$display("%0d clears and %0d ignored requests.", pool.n_clears, pool.n_ignored);
		if (pool.errors == 0 && pool.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/lfa_pkg.sv
hdl/lfa_ram.sv
hdl/lowest_free_id_allocator.sv
hdl/lfa_checker.sv
test/id_pool_tb_pkg.sv
test/tb_lowest_free_id_allocator.sv
